// ===== sv/pmtsp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the program map section parser.
// Used by pmtsp_core and program_map_section_parser; depends on nothing else.
package pmtsp_pkg;

    // Parser phases of one section.
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_POINTER,
        PH_HEADER,
        PH_PROG_DESC,
        PH_ENTRY,
        PH_ES_DESC,
        PH_CRC
    } phase_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_BAD_TABLE   = 2'd1,
        ST_BAD_ZERO    = 2'd2
    } status_t;

    // Configuration register indexes.
    localparam logic REG_TABLE_ID    = 1'b0;
    localparam logic REG_STREAM_TYPE = 1'b1;

    // Section layout constants.
    localparam int HEADER_TAIL_BYTES = 9;
    localparam int ENTRY_BYTES       = 5;
    localparam int CRC_BYTES         = 4;

    localparam int REM_W = 14;
    localparam logic [3:0] HDR_LAST_IDX = 4'd11;
    localparam logic [3:0] ENT_LAST_IDX = 4'(ENTRY_BYTES - 1);
    localparam logic [3:0] CRC_LAST_IDX = 4'(CRC_BYTES - 1);

    localparam logic signed [REM_W-1:0] HDR_TAIL_S = REM_W'(HEADER_TAIL_BYTES);
    localparam logic signed [REM_W-1:0] ENTRY_S    = REM_W'(ENTRY_BYTES);
    localparam logic signed [REM_W-1:0] CRC_S      = REM_W'(CRC_BYTES);

    localparam int OUT_TDATA_W = 96;

    // One summary result.
    typedef struct packed {
        status_t     status;
        logic        syntax_indicator;
        logic [11:0] section_len;
        logic [15:0] program_num;
        logic [4:0]  version;
        logic        current_next;
        logic [7:0]  section_index;
        logic [7:0]  last_section_index;
        logic [12:0] pcr_pid;
        logic [11:0] program_info_len;
        logic        video_found;
        logic [12:0] video_pid;
    } pmtsp_result_t;

endpackage

// ===== sv/pmtsp_core.sv =====
`timescale 1ns / 1ps
// Per-byte section parsing state machine and field capture.
// Depends on pmtsp_pkg; instantiated by program_map_section_parser.
module pmtsp_core (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    step,
    input  logic [7:0]              data_byte,
    input  logic                    section_start,
    input  logic [7:0]              pmt_table_id,
    input  logic [7:0]              wanted_stream_type,
    output logic                    res_valid,
    output pmtsp_pkg::pmtsp_result_t res
);
    import pmtsp_pkg::*;

    phase_t                   phase_reg, phase_next;
    logic [11:0]              skip_reg, skip_next;
    logic signed [REM_W-1:0]  remaining_reg, remaining_next;
    logic [3:0]               idx_reg, idx_next;

    logic                     syntax_reg, syntax_next;
    logic [11:0]              section_len_reg, section_len_next;
    logic [15:0]              program_num_reg, program_num_next;
    logic [4:0]               version_reg, version_next;
    logic                     current_next_reg, current_next_next;
    logic [7:0]               section_index_reg, section_index_next;
    logic [7:0]               last_index_reg, last_index_next;
    logic [12:0]              pcr_pid_reg, pcr_pid_next;
    logic [11:0]              pil_reg, pil_next;

    logic [7:0]               stream_type_reg, stream_type_next;
    logic [12:0]              ent_pid_reg, ent_pid_next;
    logic [11:0]              es_len_reg, es_len_next;

    logic                     found_reg, found_next;
    logic [12:0]              vpid_reg, vpid_next;

    logic [11:0]              skip_dec;
    logic [11:0]              pil_full;
    logic [11:0]              es_full;
    logic                     table_bad;
    logic                     zero_bad;
    logic                     crc_done;
    logic                     more_entries;

    assign skip_dec  = skip_reg - 12'd1;
    assign pil_full  = {pil_reg[11:8], data_byte};
    assign es_full   = {es_len_reg[11:8], data_byte};
    assign table_bad = (phase_reg == PH_HEADER) && (idx_reg == 4'd0)
                       && (data_byte != pmt_table_id);
    assign zero_bad  = (phase_reg == PH_HEADER) && (idx_reg == 4'd1) && data_byte[6];
    assign crc_done  = (phase_reg == PH_CRC) && (idx_reg == CRC_LAST_IDX);
    assign more_entries = (remaining_next > CRC_S);

    // Field capture and counters.
    always_comb
    begin
        skip_next          = skip_reg;
        remaining_next     = remaining_reg;
        idx_next           = idx_reg;
        syntax_next        = syntax_reg;
        section_len_next   = section_len_reg;
        program_num_next   = program_num_reg;
        version_next       = version_reg;
        current_next_next  = current_next_reg;
        section_index_next = section_index_reg;
        last_index_next    = last_index_reg;
        pcr_pid_next       = pcr_pid_reg;
        pil_next           = pil_reg;
        stream_type_next   = stream_type_reg;
        ent_pid_next       = ent_pid_reg;
        es_len_next        = es_len_reg;
        found_next         = found_reg;
        vpid_next          = vpid_reg;

        if (section_start)
        begin
            skip_next          = {4'd0, data_byte};
            remaining_next     = '0;
            idx_next           = '0;
            syntax_next        = 1'b0;
            section_len_next   = '0;
            program_num_next   = '0;
            version_next       = '0;
            current_next_next  = 1'b0;
            section_index_next = '0;
            last_index_next    = '0;
            pcr_pid_next       = '0;
            pil_next           = '0;
            stream_type_next   = '0;
            ent_pid_next       = '0;
            es_len_next        = '0;
            found_next         = 1'b0;
            vpid_next          = '0;
        end
        else
        begin
            case (phase_reg)
                PH_POINTER, PH_PROG_DESC, PH_ES_DESC:
                begin
                    skip_next = skip_dec;
                    if (skip_dec == 12'd0)
                    begin
                        idx_next = '0;
                    end
                end
                PH_HEADER:
                begin
                    if (idx_reg < HDR_LAST_IDX)
                    begin
                        idx_next = idx_reg + 4'd1;
                    end
                    case (idx_reg)
                        4'd0: ;
                        4'd1:
                        begin
                            syntax_next      = data_byte[7];
                            section_len_next = {data_byte[3:0], 8'd0};
                        end
                        4'd2:  section_len_next   = {section_len_reg[11:8], data_byte};
                        4'd3:  program_num_next   = {data_byte, 8'd0};
                        4'd4:  program_num_next   = {program_num_reg[15:8], data_byte};
                        4'd5:
                        begin
                            version_next      = data_byte[5:1];
                            current_next_next = data_byte[0];
                        end
                        4'd6:  section_index_next = data_byte;
                        4'd7:  last_index_next    = data_byte;
                        4'd8:  pcr_pid_next       = {data_byte[4:0], 8'd0};
                        4'd9:  pcr_pid_next       = {pcr_pid_reg[12:8], data_byte};
                        4'd10: pil_next           = {data_byte[3:0], 8'd0};
                        default:
                        begin
                            pil_next       = pil_full;
                            remaining_next = $signed({2'b00, section_len_reg}) - HDR_TAIL_S
                                             - $signed({2'b00, pil_full});
                            skip_next      = pil_full;
                            idx_next       = '0;
                        end
                    endcase
                end
                PH_ENTRY:
                begin
                    idx_next = idx_reg + 4'd1;
                    case (idx_reg)
                        4'd0: stream_type_next = data_byte;
                        4'd1: ent_pid_next     = {data_byte[4:0], 8'd0};
                        4'd2: ent_pid_next     = {ent_pid_reg[12:8], data_byte};
                        4'd3: es_len_next      = {data_byte[3:0], 8'd0};
                        default:
                        begin
                            es_len_next = es_full;
                            if (stream_type_reg == wanted_stream_type)
                            begin
                                found_next = 1'b1;
                                vpid_next  = ent_pid_reg;
                            end
                            remaining_next = remaining_reg - ENTRY_S
                                             - $signed({2'b00, es_full});
                            skip_next      = es_full;
                            idx_next       = '0;
                        end
                    endcase
                end
                PH_CRC:
                begin
                    idx_next = crc_done ? 4'd0 : idx_reg + 4'd1;
                end
                default: ;
            endcase
        end
    end

    // Next phase.
    always_comb
    begin
        phase_next = phase_reg;
        if (section_start)
        begin
            phase_next = (data_byte != 8'd0) ? PH_POINTER : PH_HEADER;
        end
        else
        begin
            unique case (phase_reg)
                PH_IDLE: phase_next = PH_IDLE;
                PH_POINTER:
                begin
                    if (skip_dec == 12'd0)
                    begin
                        phase_next = PH_HEADER;
                    end
                end
                PH_HEADER:
                begin
                    if (table_bad || zero_bad)
                    begin
                        phase_next = PH_IDLE;
                    end
                    else if (idx_reg >= HDR_LAST_IDX)
                    begin
                        if (pil_full != 12'd0)
                        begin
                            phase_next = PH_PROG_DESC;
                        end
                        else
                        begin
                            phase_next = more_entries ? PH_ENTRY : PH_CRC;
                        end
                    end
                end
                PH_PROG_DESC, PH_ES_DESC:
                begin
                    if (skip_dec == 12'd0)
                    begin
                        phase_next = more_entries ? PH_ENTRY : PH_CRC;
                    end
                end
                PH_ENTRY:
                begin
                    if (idx_reg >= ENT_LAST_IDX)
                    begin
                        if (es_full != 12'd0)
                        begin
                            phase_next = PH_ES_DESC;
                        end
                        else
                        begin
                            phase_next = more_entries ? PH_ENTRY : PH_CRC;
                        end
                    end
                end
                PH_CRC:
                begin
                    if (crc_done)
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                default: phase_next = PH_IDLE;
            endcase
        end
    end

    // Result outputs. res_valid says whether the held byte makes a result; the
    // top level decides whether the byte is consumed in this cycle.
    always_comb
    begin
        res       = '0;
        res_valid = !section_start && (table_bad || zero_bad || crc_done);
        if (table_bad)
        begin
            res.status = ST_BAD_TABLE;
        end
        else if (zero_bad)
        begin
            res.status           = ST_BAD_ZERO;
            res.syntax_indicator = data_byte[7];
        end
        else
        begin
            res.status             = ST_OK;
            res.syntax_indicator   = syntax_reg;
            res.section_len        = section_len_reg;
            res.program_num        = program_num_reg;
            res.version            = version_reg;
            res.current_next       = current_next_reg;
            res.section_index      = section_index_reg;
            res.last_section_index = last_index_reg;
            res.pcr_pid            = pcr_pid_reg;
            res.program_info_len   = pil_reg;
            res.video_found        = found_reg;
            res.video_pid          = vpid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            skip_reg          <= '0;
            remaining_reg     <= '0;
            idx_reg           <= '0;
            syntax_reg        <= 1'b0;
            section_len_reg   <= '0;
            program_num_reg   <= '0;
            version_reg       <= '0;
            current_next_reg  <= 1'b0;
            section_index_reg <= '0;
            last_index_reg    <= '0;
            pcr_pid_reg       <= '0;
            pil_reg           <= '0;
            stream_type_reg   <= '0;
            ent_pid_reg       <= '0;
            es_len_reg        <= '0;
            found_reg         <= 1'b0;
            vpid_reg          <= '0;
        end
        else if (step)
        begin
            phase_reg         <= phase_next;
            skip_reg          <= skip_next;
            remaining_reg     <= remaining_next;
            idx_reg           <= idx_next;
            syntax_reg        <= syntax_next;
            section_len_reg   <= section_len_next;
            program_num_reg   <= program_num_next;
            version_reg       <= version_next;
            current_next_reg  <= current_next_next;
            section_index_reg <= section_index_next;
            last_index_reg    <= last_index_next;
            pcr_pid_reg       <= pcr_pid_next;
            pil_reg           <= pil_next;
            stream_type_reg   <= stream_type_next;
            ent_pid_reg       <= ent_pid_next;
            es_len_reg        <= es_len_next;
            found_reg         <= found_next;
            vpid_reg          <= vpid_next;
        end
    end

endmodule

// ===== sv/program_map_section_parser.sv =====
`timescale 1ns / 1ps
// Top level of the program map section parser: input register, output register
// and configuration registers around pmtsp_core. Depends on pmtsp_pkg.
//
// Usage:
//   Section bytes enter on the slave stream, one byte per item in s_tdata, with
//   s_tuser high on the pointer field byte that opens a section. A section start
//   in the middle of a section abandons the old one. When the four CRC bytes
//   have passed, or as soon as the table id or the fixed zero bit is wrong, one
//   summary item leaves on the master stream; other bytes produce no item.
//   The configuration port writes the accepted table id (index 0) and the
//   wanted stream type (index 1); write it only while the parser is idle.
// Timing:
//   An accepted byte is held in the input register, is parsed by the
//   per-byte state update, and a summary that it makes lands in the output
//   register, which drives m_tvalid. One byte is taken every cycle unless a
//   new summary has to wait for the full output slot to drain.
// Reset and stalls:
//   Reset empties both registers, returns the parser to idle and loads both
//   configuration registers with 2. While the receiver holds m_tready low with
//   a summary waiting, the next byte is still parsed if it produces no result;
//   the input stalls only when a new summary would need the full output slot.
module program_map_section_parser (
    input  logic        clk,
    input  logic        rst_n,
    // Slave stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] section_start
    // Master stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata from bit 0 up: status[1:0], syntax_indicator[2], section_len[14:3],
    // program_num[30:15], version[35:31], current_next[36], section_index[44:37],
    // last_section_index[52:45], pcr_pid[65:53], program_info_len[77:66],
    // video_found[78], video_pid[91:79], zero fill[95:92].
    output logic [pmtsp_pkg::OUT_TDATA_W-1:0] m_tdata,
    // Configuration write port.
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [7:0]  cfg_wdata
);
    import pmtsp_pkg::*;

    logic           in_valid_reg, in_valid_next;
    logic [7:0]     in_byte_reg;
    logic           in_start_reg;
    logic           out_valid_reg, out_valid_next;
    pmtsp_result_t  out_res_reg;
    logic [7:0]     table_id_reg;
    logic [7:0]     stream_type_reg;

    logic           advance;
    logic           res_valid;
    pmtsp_result_t  res;

    // The parser consumes the held byte unless it makes a result while the
    // output slot is full and not being drained.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready || !res_valid);
    assign s_tready = !in_valid_reg || advance;

    assign in_valid_next  = (s_tvalid && s_tready) || (in_valid_reg && !advance);
    assign out_valid_next = (advance && res_valid) ? 1'b1
                          : (m_tready ? 1'b0 : out_valid_reg);

    pmtsp_core u_core (
        .clk                (clk),
        .rst_n              (rst_n),
        .step               (advance),
        .data_byte          (in_byte_reg),
        .section_start      (in_start_reg),
        .pmt_table_id       (table_id_reg),
        .wanted_stream_type (stream_type_reg),
        .res_valid          (res_valid),
        .res                (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg  <= s_tdata;
            in_start_reg <= s_tuser;
        end
        if (advance && res_valid)
        begin
            out_res_reg <= res;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_id_reg    <= 8'd2;
            stream_type_reg <= 8'd2;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                REG_TABLE_ID:    table_id_reg    <= cfg_wdata;
                REG_STREAM_TYPE: stream_type_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0,
                       out_res_reg.video_pid,
                       out_res_reg.video_found,
                       out_res_reg.program_info_len,
                       out_res_reg.pcr_pid,
                       out_res_reg.last_section_index,
                       out_res_reg.section_index,
                       out_res_reg.current_next,
                       out_res_reg.version,
                       out_res_reg.program_num,
                       out_res_reg.section_len,
                       out_res_reg.syntax_indicator,
                       out_res_reg.status};

    // A wrong table id summary carries nothing but its status.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_res_reg.status == ST_BAD_TABLE) |-> (m_tdata[91:2] == '0))
        else $error("wrong table id summary carries nonzero fields");

    // No matching entry means no elementary PID is reported.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !out_res_reg.video_found) |-> (out_res_reg.video_pid == '0))
        else $error("video pid reported without a match");

    // The input stalls only behind a full, blocked output slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready && res_valid))
        else $error("input stalled without a blocked result");

    // A result taken into the output slot is never dropped.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && res_valid) |=> out_valid_reg)
        else $error("parsed result lost");

endmodule
